// ===== design/rrip_pkg.sv =====
// ---------------------------------------------------------------------------
// rrip_pkg
// Shared types and constants of the dueling-insertion RRIP replacement core.
// ---------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

    localparam int SETS          = 2048;
    localparam int WAYS          = 16;
    localparam int LEADER_SETS   = 64;
    localparam int SELECTOR_BITS = 10;

    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int RRV_BITS  = 2;
    localparam int ROW_BITS  = WAYS * RRV_BITS;
    localparam int CNT_BITS  = 5;

    localparam logic [RRV_BITS-1:0]      RRV_MAX  = 2'd3;
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_HALF =
        SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);

    // command kinds
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic        hit_flag;
        logic [15:0] valid_mask;
    } cmd_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [1:0] inserted_value;
        logic       bip_mode;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/rrip_dip_set_dueling_replacement_core.sv =====
// ---------------------------------------------------------------------------
// rrip_dip_set_dueling_replacement_core
// RRIP replacement engine with set-dueling insertion policy selection.
// ---------------------------------------------------------------------------
// Usage:
//   A command word on cmd is taken at a rising edge with start high and busy
//   low. It is either a victim query (set + valid mask) or a state update
//   after an access (set + way + hit flag).
//   Each command produces exactly one response word on rsp, marked by done
//   for one cycle; done is registered as the command leaves the execute
//   state. The receiver cannot stall; done is a plain strobe.
//   Each command is handled in order: the set's row of re-reference values
//   is read from the row memory as the command is taken, then modified and
//   written back in the execute state (a query that finds an invalid way
//   writes nothing). busy is high in that state, so no new command is taken.
//   After reset the core sweeps the row memory, writing every entry to 3,
//   one row per cycle with busy high. The duel selector resets to mid-scale
//   and the update counter to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module rrip_dip_set_dueling_replacement_core
    import rrip_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output rsp_t      rsp
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [SET_BITS-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic [CNT_BITS-1:0]      upd_cnt_reg, upd_cnt_next;
    logic                     done_reg, done_next;
    rsp_t                     rsp_reg, rsp_next;
    cmd_t                     cmd_reg;

    logic [ROW_BITS-1:0] mem [SETS];
    logic [ROW_BITS-1:0] rd_row_reg;

    logic                accept;
    logic                mem_we;
    logic [SET_BITS-1:0] mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;

    // execute-stage signals
    logic [SET_BITS-1:0] set_idx;
    logic [WAY_BITS-1:0] way_idx;
    logic [WAYS-1:0]     invalid;
    logic                any_invalid;
    logic [WAY_BITS-1:0] first_invalid;
    logic [RRV_BITS-1:0] rrv      [WAYS];
    logic [RRV_BITS-1:0] aged     [WAYS];
    logic                any3, any2, any1;
    logic [RRV_BITS-1:0] top, age_add;
    logic [WAY_BITS-1:0] first_max;
    logic [ROW_BITS-1:0] aged_row, upd_row;
    logic                lead_lru, lead_bip;
    logic [RRV_BITS-1:0] ins;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign set_idx = cmd_reg.set_index[SET_BITS-1:0];
    assign way_idx = cmd_reg.way_index[WAY_BITS-1:0];
    assign invalid = ~cmd_reg.valid_mask[WAYS-1:0];
    assign any_invalid = |invalid;

    // victim side: lowest invalid way, else age the row
    always_comb
    begin
        first_invalid = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (invalid[w])
                first_invalid = WAY_BITS'(w);
        end
    end

    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            rrv[w] = rd_row_reg[w*RRV_BITS +: RRV_BITS];
            any3 = any3 | (rrv[w] == 2'd3);
            any2 = any2 | (rrv[w] == 2'd2);
            any1 = any1 | (rrv[w] == 2'd1);
        end
        top     = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
        age_add = RRV_MAX - top;
    end

    always_comb
    begin
        first_max = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            aged[w] = rrv[w] + age_add;
            aged_row[w*RRV_BITS +: RRV_BITS] = aged[w];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (aged[w] == RRV_MAX)
                first_max = WAY_BITS'(w);
        end
    end

    // update side: insertion value and selector
    assign lead_lru = (set_idx < SET_BITS'(LEADER_SETS));
    assign lead_bip = !lead_lru && (set_idx < SET_BITS'(2 * LEADER_SETS));

    always_comb
    begin
        upd_cnt_next = upd_cnt_reg;
        sel_next     = sel_reg;
        ins          = '0;
        if (cmd_reg.kind == KIND_UPDATE)
        begin
            upd_cnt_next = upd_cnt_reg + CNT_BITS'(1);
            if (cmd_reg.hit_flag)
            begin
                ins = '0;
                if (lead_lru && (sel_reg != SEL_MAX))
                    sel_next = sel_reg + SELECTOR_BITS'(1);
                if (lead_bip && (sel_reg != '0))
                    sel_next = sel_reg - SELECTOR_BITS'(1);
            end
            else if (lead_lru)
                ins = RRV_MAX;
            else if (lead_bip || (sel_reg < SEL_HALF))
                ins = (upd_cnt_next == '0) ? 2'd0 : RRV_MAX;
            else
                ins = RRV_MAX;
        end
    end

    always_comb
    begin
        upd_row = rd_row_reg;
        upd_row[way_idx*RRV_BITS +: RRV_BITS] = ins;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mem_we       = 1'b0;
        mem_waddr    = set_idx;
        mem_wdata    = upd_row;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = {ROW_BITS{1'b1}};
                clr_cnt_next = clr_cnt_reg + SET_BITS'(1);
                if (clr_cnt_reg == SET_BITS'(SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                done_next = 1'b1;
                rsp_next.bip_mode = (sel_next < SEL_HALF);
                if (cmd_reg.kind == KIND_QUERY)
                begin
                    rsp_next.inserted_value = '0;
                    if (any_invalid)
                        rsp_next.victim_way = first_invalid;
                    else
                    begin
                        rsp_next.victim_way = first_max;
                        mem_we    = 1'b1;
                        mem_wdata = aged_row;
                    end
                end
                else
                begin
                    rsp_next.victim_way     = '0;
                    rsp_next.inserted_value = ins;
                    mem_we = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            sel_reg     <= SEL_HALF;
            upd_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (state_reg == ST_EXEC)
            begin
                sel_reg     <= sel_next;
                upd_cnt_reg <= upd_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
            cmd_reg <= cmd;
    end

    // row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_row_reg <= mem[cmd.set_index[SET_BITS-1:0]];
    end

endmodule

`default_nettype wire

// ===== design/rrip_core_chk.sv =====
// ---------------------------------------------------------------------------
// rrip_core_chk
// Port-level checks of the replacement core, bound to the core module.
// ---------------------------------------------------------------------------
`default_nettype none

module rrip_core_chk
    import rrip_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire cmd_t cmd,
    input wire logic done,
    input wire rsp_t rsp
);

    // every taken word must be answered by a done strobe
    a_resp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("missing response after command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("response without command");

    a_query_ins: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd.kind, 2) == KIND_QUERY)) |-> (rsp.inserted_value == 2'd0))
        else $error("query reported an inserted value");

    a_update_way: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd.kind, 2) == KIND_UPDATE)) |-> (rsp.victim_way == 4'd0))
        else $error("update reported a victim way");

endmodule

bind rrip_dip_set_dueling_replacement_core rrip_core_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
